// ===== rtl/decimal_text_to_fixed_point_macros.svh =====
// Assertion macros used by the checker file of the decimal text converter.
`ifndef DECIMAL_TEXT_TO_FIXED_POINT_MACROS_SVH
`define DECIMAL_TEXT_TO_FIXED_POINT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, masked during reset.
`define DTFP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, masked during reset.
`define DTFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/dtfp_pkg.sv =====
// Types and constants shared by the decimal text to fixed-point converter.
package dtfp_pkg;

   localparam logic [7:0] CHAR_END    = 8'h00;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_POINT  = 8'h2E;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_SUFFIX = 8'h66;

   localparam int VALUE_W = 48;
   localparam int MAG_W   = 47;
   localparam int FRAC_Q  = 32;

   localparam logic [MAG_W-1:0]   MAG_LIMIT = '1;
   localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {MAG_W{1'b0}}};

   // Fraction digit count saturates here; the weight is zero from this step on.
   localparam logic [3:0] WEIGHT_LAST = 4'd9;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   typedef enum logic [2:0] {
      KIND_DIGIT,
      KIND_POINT,
      KIND_MINUS,
      KIND_SUFFIX,
      KIND_BAD,
      KIND_END
   } dtfp_kind_type;

   typedef struct packed {
      dtfp_kind_type kind;
      logic [3:0]    digit;
   } dtfp_op_type;

   typedef struct packed {
      logic        valid;
      dtfp_op_type op;
   } dtfp_head_type;

   // Q0.32 weight of the fraction digit that follows the given number of
   // fraction digits; each entry is the previous one divided by ten, rounded.
   function automatic logic [31:0] dtfp_weight(input logic [3:0] step);
      logic [31:0] weight;
      case (step)
         4'd0:    weight = 32'd429496730;
         4'd1:    weight = 32'd42949673;
         4'd2:    weight = 32'd4294967;
         4'd3:    weight = 32'd429497;
         4'd4:    weight = 32'd42950;
         4'd5:    weight = 32'd4295;
         4'd6:    weight = 32'd430;
         4'd7:    weight = 32'd43;
         4'd8:    weight = 32'd4;
         default: weight = 32'd0;
      endcase
      return weight;
   endfunction

endpackage

// ===== rtl/dtfp_front.sv =====
// Front end: sorts each incoming character into a parse operation.
module dtfp_front
   import dtfp_pkg::*;
(
   input  logic [7:0]  req_character,
   output dtfp_op_type op
);

   logic [3:0] digit_offset;

   assign digit_offset = 4'(req_character - CHAR_ZERO);

   always_comb begin
      op.digit = digit_offset;
      if (req_character == CHAR_END) begin
         op.kind = KIND_END;
      end else if (req_character == CHAR_SUFFIX) begin
         op.kind = KIND_SUFFIX;
      end else if (req_character == CHAR_MINUS) begin
         op.kind = KIND_MINUS;
      end else if (req_character == CHAR_POINT) begin
         op.kind = KIND_POINT;
      end else if (req_character >= CHAR_ZERO && req_character <= CHAR_NINE) begin
         op.kind = KIND_DIGIT;
      end else begin
         op.kind = KIND_BAD;
      end
   end

endmodule

// ===== rtl/dtfp_queue.sv =====
// Short queue of classified operations between the front and back ends.
module dtfp_queue
   import dtfp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  dtfp_op_type   push_op,
   output logic          full,
   input  logic          pop,
   output dtfp_head_type head
);

   dtfp_op_type            entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign do_push    = push && !full;
   assign head.valid = (count_ff != '0);
   assign head.op    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      case ({do_push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ===== rtl/dtfp_back.sv =====
// Back end: runs the parse state on each operation and registers the result.
module dtfp_back
   import dtfp_pkg::*;
#(
   parameter int INT_BITS  = 31,
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dtfp_head_type             head,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [VALUE_W-1:0] rsp_value,
   output logic                      rsp_ok
);

   localparam int INT_W4 = INT_BITS + 4;
   localparam int SUM_W  = (INT_BITS + FRAC_BITS + 1 > VALUE_W) ?
                           INT_BITS + FRAC_BITS + 1 : VALUE_W;

   logic                first_ff, first_in;
   logic                negative_ff, negative_in;
   logic                point_ff, point_in;
   logic                suffix_ff, suffix_in;
   logic                malformed_ff, malformed_in;
   logic [INT_BITS-1:0] int_ff, int_in;
   logic [31:0]         frac_ff, frac_in;
   logic [3:0]          wcount_ff, wcount_in;

   logic                out_valid_ff, out_valid_in;
   logic [MAG_W-1:0]    out_mag_ff;
   logic                out_neg_ff;
   logic                out_ok_ff;

   logic                slot_free;
   logic                end_pop;
   logic [INT_W4-1:0]   int_wide;
   logic [INT_BITS-1:0] int_next;
   logic [35:0]         frac_prod;
   logic [35:0]         frac_wide;
   logic [31:0]         frac_next;
   logic [FRAC_BITS:0]  frac_round;
   logic [SUM_W-1:0]    mag_sum;
   logic [MAG_W-1:0]    mag;

   assign slot_free = !out_valid_ff || !rsp_stall;
   assign pop       = head.valid && (head.op.kind != KIND_END || slot_free);
   assign end_pop   = pop && head.op.kind == KIND_END;

   // Horner step: times ten as shift-and-add, then saturate.
   assign int_wide = INT_W4'({int_ff, 3'b000}) + INT_W4'({int_ff, 1'b0})
                   + INT_W4'(head.op.digit);
   assign int_next = (int_wide[INT_W4-1:INT_BITS] != '0) ? '1 : int_wide[INT_BITS-1:0];

   assign frac_prod = 36'(head.op.digit) * 36'(dtfp_weight(wcount_ff));
   assign frac_wide = 36'(frac_ff) + frac_prod;
   assign frac_next = (frac_wide[35:32] != '0) ? '1 : frac_wide[31:0];

   // Round the Q0.32 fraction to nearest, half up; a carry lands in the top bit.
   if (FRAC_BITS < FRAC_Q) begin : g_round
      logic [FRAC_Q:0] frac_half_sum;
      assign frac_half_sum = (FRAC_Q + 1)'(frac_ff) + ((FRAC_Q + 1)'(1) << (31 - FRAC_BITS));
      assign frac_round    = frac_half_sum[FRAC_Q:FRAC_Q-FRAC_BITS];
   end else begin : g_exact
      assign frac_round = (FRAC_BITS + 1)'(frac_ff);
   end

   assign mag_sum = (SUM_W'(int_ff) << FRAC_BITS) + SUM_W'(frac_round);
   assign mag     = (mag_sum > SUM_W'(MAG_LIMIT)) ? MAG_LIMIT : mag_sum[MAG_W-1:0];

   always_comb begin
      first_in     = first_ff;
      negative_in  = negative_ff;
      point_in     = point_ff;
      suffix_in    = suffix_ff;
      malformed_in = malformed_ff;
      int_in       = int_ff;
      frac_in      = frac_ff;
      wcount_in    = wcount_ff;
      if (end_pop) begin
         first_in     = 1'b1;
         negative_in  = 1'b0;
         point_in     = 1'b0;
         suffix_in    = 1'b0;
         malformed_in = 1'b0;
         int_in       = '0;
         frac_in      = '0;
         wcount_in    = '0;
      end else if (pop) begin
         first_in = 1'b0;
         // Drop everything once malformed or past the suffix.
         if (!malformed_ff && !suffix_ff) begin
            case (head.op.kind)
               KIND_SUFFIX: suffix_in = 1'b1;
               KIND_MINUS: begin
                  if (first_ff) begin
                     negative_in = 1'b1;
                  end else begin
                     malformed_in = 1'b1;
                  end
               end
               KIND_POINT: begin
                  if (point_ff) begin
                     malformed_in = 1'b1;
                  end else begin
                     point_in = 1'b1;
                  end
               end
               KIND_DIGIT: begin
                  if (!point_ff) begin
                     int_in = int_next;
                  end else begin
                     frac_in = frac_next;
                     if (wcount_ff != WEIGHT_LAST) begin
                        wcount_in = wcount_ff + 1'b1;
                     end
                  end
               end
               KIND_BAD: malformed_in = 1'b1;
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (end_pop) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff     <= 1'b1;
         negative_ff  <= 1'b0;
         point_ff     <= 1'b0;
         suffix_ff    <= 1'b0;
         malformed_ff <= 1'b0;
         int_ff       <= '0;
         frac_ff      <= '0;
         wcount_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         first_ff     <= first_in;
         negative_ff  <= negative_in;
         point_ff     <= point_in;
         suffix_ff    <= suffix_in;
         malformed_ff <= malformed_in;
         int_ff       <= int_in;
         frac_ff      <= frac_in;
         wcount_ff    <= wcount_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (end_pop) begin
         out_mag_ff <= malformed_ff ? '0 : mag;
         out_neg_ff <= negative_ff && !malformed_ff;
         out_ok_ff  <= !malformed_ff;
      end
   end

   // Apply the sign last so rounding stays symmetric about zero.
   assign rsp_valid = out_valid_ff;
   assign rsp_ok    = out_ok_ff;
   assign rsp_value = out_neg_ff ? VALUE_W'(0) - VALUE_W'(out_mag_ff) : VALUE_W'(out_mag_ff);

endmodule

// ===== rtl/decimal_text_to_fixed_point.sv =====
// A terminator is written into the queue, popped by the back end once its result
// register is free, and registered there; rsp_valid then rises with the result.
// The converter takes one character per cycle while req_stall is low; a
// four-entry queue absorbs stalls on the result side.
// Reset (synchronous): empties the queue, clears the parse state and drops rsp_valid.
module decimal_text_to_fixed_point
   import dtfp_pkg::*;
#(
   parameter int INT_BITS  = 31,
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_character,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [VALUE_W-1:0] rsp_value,
   output logic                      rsp_ok
);

   dtfp_op_type   front_op;
   dtfp_head_type queue_head;
   logic          queue_full;
   logic          queue_pop;

   assign req_stall = queue_full;

   dtfp_front u_front (
      .req_character (req_character),
      .op            (front_op)
   );

   dtfp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (req_valid),
      .push_op (front_op),
      .full    (queue_full),
      .pop     (queue_pop),
      .head    (queue_head)
   );

   dtfp_back #(
      .INT_BITS  (INT_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (queue_head),
      .pop       (queue_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_value (rsp_value),
      .rsp_ok    (rsp_ok)
   );

endmodule

// ===== rtl/dtfp_checker.sv =====
// Port-level checks on the converter's result channel, bound to the top level.
`include "decimal_text_to_fixed_point_macros.svh"

module dtfp_checker
   import dtfp_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic signed [VALUE_W-1:0] rsp_value,
   input logic                      rsp_ok
);

   `DTFP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_value) && $stable(rsp_ok), "stalled result item changed")
   `DTFP_ASSERT_NOW(a_bad_is_zero, clock, reset, rsp_valid && !rsp_ok, rsp_value == '0, "malformed item carries a non-zero value")
   `DTFP_ASSERT_NOW(a_symmetric_sat, clock, reset, rsp_valid, rsp_value != VALUE_MIN, "value beyond the symmetric saturation limit")

endmodule

bind decimal_text_to_fixed_point dtfp_checker u_dtfp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_value (rsp_value),
   .rsp_ok    (rsp_ok)
);

// ===== tb/sv/decimal_text_to_fixed_point_checker.sv =====
// Checker for the decimal text converter: predicts each conversion and compares the results.
module decimal_text_to_fixed_point_checker
   import dtfp_pkg::*;
#(
   parameter int INT_BITS  = 31,
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic [7:0]                req_character,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic signed [VALUE_W-1:0] rsp_value,
   input  logic                      rsp_ok,
   output int                        fail_count,
   output int                        conversions_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] TENTH_Q32 = 64'h1999_999A;
   localparam logic [63:0] FRAC_MAX  = 64'hFFFF_FFFF;
   localparam logic [63:0] MAG_CAP   = 64'(MAG_LIMIT);
   localparam int          REPORT_LIMIT = 10;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               ok;
   } conversion_type;

   conversion_type expected_conversions[$];

   logic        at_first_char;
   logic        negative;
   logic        seen_point;
   logic        suffix_seen;
   logic        malformed;
   logic [63:0] integer_sum;
   logic [63:0] fraction_sum;
   logic [63:0] digit_weight;

   initial begin
      fail_count = 0;
      conversions_pending = 0;
   end

   function automatic dtfp_kind_type classify_character(input logic [7:0] c);
      if (c == CHAR_END) return KIND_END;
      if (c == CHAR_SUFFIX) return KIND_SUFFIX;
      if (c == CHAR_MINUS) return KIND_MINUS;
      if (c == CHAR_POINT) return KIND_POINT;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return KIND_DIGIT;
      return KIND_BAD;
   endfunction

   task automatic clear_parse();
      at_first_char = 1'b1;
      negative      = 1'b0;
      seen_point    = 1'b0;
      suffix_seen   = 1'b0;
      malformed     = 1'b0;
      integer_sum   = '0;
      fraction_sum  = '0;
      digit_weight  = TENTH_Q32;
   endtask

   // Round the fraction to the output width, then join and saturate the magnitude.
   function automatic logic [63:0] fixed_magnitude();
      logic [63:0] frac;
      logic [63:0] mag;
      frac = fraction_sum;
      if (FRAC_BITS < 32) begin
         frac = (frac + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
      end
      if (integer_sum > (MAG_CAP >> FRAC_BITS)) return MAG_CAP;
      mag = (integer_sum << FRAC_BITS) + frac;
      if (mag > MAG_CAP) mag = MAG_CAP;
      return mag;
   endfunction

   task automatic parse_character(input logic [7:0] c);
      dtfp_kind_type  kind;
      logic           first;
      logic [63:0]    digit;
      logic [63:0]    next;
      logic [63:0]    mag;
      conversion_type result;
      kind  = classify_character(c);
      first = at_first_char;
      if (kind == KIND_END) begin
         if (malformed) begin
            result = '0;
         end else begin
            mag = fixed_magnitude();
            if (negative) mag = -mag;
            result.value = mag[VALUE_W-1:0];
            result.ok    = 1'b1;
         end
         expected_conversions.push_back(result);
         clear_parse();
      end else begin
         at_first_char = 1'b0;
         if (!malformed && !suffix_seen) begin
            case (kind)
               KIND_SUFFIX: begin
                  suffix_seen = 1'b1;
               end
               KIND_MINUS: begin
                  if (first) negative = 1'b1;
                  else malformed = 1'b1;
               end
               KIND_POINT: begin
                  if (seen_point) malformed = 1'b1;
                  else seen_point = 1'b1;
               end
               KIND_DIGIT: begin
                  digit = 64'(c - CHAR_ZERO);
                  if (!seen_point) begin
                     next = integer_sum * 64'd10 + digit;
                     integer_sum = (next > ((64'd1 << INT_BITS) - 64'd1)) ?
                                   ((64'd1 << INT_BITS) - 64'd1) : next;
                  end else begin
                     next = fraction_sum + digit * digit_weight;
                     fraction_sum = (next > FRAC_MAX) ? FRAC_MAX : next;
                     digit_weight = (digit_weight + 64'd5) / 64'd10;
                  end
               end
               default: begin
                  malformed = 1'b1;
               end
            endcase
         end
      end
   endtask

   task automatic compare_result();
      conversion_type want;
      if (expected_conversions.size() == 0) begin
         if (fail_count < REPORT_LIMIT) begin
            $display("unexpected result: value %0d ok %0b", rsp_value, rsp_ok);
         end
         fail_count++;
      end else begin
         want = expected_conversions.pop_front();
         if (want.value !== rsp_value || want.ok !== rsp_ok) begin
            if (fail_count < REPORT_LIMIT) begin
               $display("mismatch: expected value %0d ok %0b, got value %0d ok %0b",
                        $signed(want.value), want.ok, rsp_value, rsp_ok);
            end
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_parse();
         expected_conversions.delete();
      end else begin
         if (rsp_valid && !rsp_stall) compare_result();
         if (req_valid && !req_stall) parse_character(req_character);
      end
      conversions_pending = expected_conversions.size();
   end

endmodule

// ===== tb/sv/decimal_text_to_fixed_point_test.sv =====
// Top of the decimal text converter test: clock, reset, character stimulus and verdict.
module decimal_text_to_fixed_point_test
   import dtfp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int INT_BITS     = 31;
   localparam int FRAC_BITS    = 16;
   localparam int RANDOM_ITEMS = 1850;
   localparam int HOLD_CYCLES  = 250;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [7:0]                req_character;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic signed [VALUE_W-1:0] rsp_value;
   logic                      rsp_ok;
   int                        fail_count;
   int                        conversions_pending;

   logic       sender_calm   = 1'b0;
   logic       receiver_calm = 1'b0;
   int         holds_requested = 0;
   int         holds_taken     = 0;
   int         items_sent      = 0;
   logic [7:0] text_q[$];

   decimal_text_to_fixed_point #(
      .INT_BITS  (INT_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_character (req_character),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value     (rsp_value),
      .rsp_ok        (rsp_ok)
   );

   decimal_text_to_fixed_point_checker #(
      .INT_BITS  (INT_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) checker_i (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_character       (req_character),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_value           (rsp_value),
      .rsp_ok              (rsp_ok),
      .fail_count          (fail_count),
      .conversions_pending (conversions_pending)
   );

   always #2 clock = ~clock;

   initial begin
      #4_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // Mostly no gap, some short ones, a few long ones.
   function automatic int idle_cycles(input logic calm);
      int roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Receiver: random stall bursts, plus a long hold-off on request.
   initial begin
      int hold_left;
      int stall_left;
      int run_left;
      hold_left  = 0;
      stall_left = 0;
      run_left   = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_taken != holds_requested) begin
            holds_taken++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else if (receiver_calm) begin
            rsp_stall = 1'b0;
         end else if (stall_left > 0) begin
            rsp_stall = 1'b1;
            stall_left--;
         end else if (run_left > 0) begin
            rsp_stall = 1'b0;
            run_left--;
         end else begin
            rsp_stall  = 1'b0;
            stall_left = idle_cycles(1'b0);
            run_left   = $urandom_range(0, 6);
         end
      end
   end

   // Offer one item from a falling edge and hold it until accepted.
   task automatic send_character(input logic [7:0] c);
      int gap;
      gap = idle_cycles(sender_calm);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_character = c;
      do @(posedge clock); while (req_stall);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_text();
      foreach (text_q[i]) send_character(text_q[i]);
      send_character(CHAR_END);
   endtask

   task automatic send_string(input string s);
      text_q.delete();
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
      send_text();
   endtask

   task automatic drain_conversions();
      req_valid = 1'b0;
      while (conversions_pending != 0) @(negedge clock);
   endtask

   function automatic logic [7:0] random_digit(input logic nines);
      if (nines) return CHAR_NINE;
      return CHAR_ZERO + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] corrupt_byte();
      case ($urandom_range(0, 3))
         0:       return CHAR_MINUS;
         1:       return CHAR_POINT;
         2:       return CHAR_SUFFIX;
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   // Mostly well-formed numerals; some with a stray byte, some pure noise.
   task automatic make_numeral();
      int   mode;
      int   count;
      int   pos;
      logic nines;
      text_q.delete();
      mode  = $urandom_range(0, 99);
      nines = ($urandom_range(0, 7) == 0);
      if (mode < 5) begin
         count = $urandom_range(1, 8);
         repeat (count) text_q.push_back(8'($urandom_range(1, 255)));
      end else begin
         if ($urandom_range(0, 2) == 0) text_q.push_back(CHAR_MINUS);
         count = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 4);
         repeat (count) text_q.push_back(random_digit(nines));
         if ($urandom_range(0, 3) != 0) begin
            text_q.push_back(CHAR_POINT);
            count = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 14) :
                                                  $urandom_range(0, 5);
            repeat (count) text_q.push_back(random_digit(nines));
         end
         if ($urandom_range(0, 7) == 0) begin
            text_q.push_back(CHAR_SUFFIX);
            count = $urandom_range(0, 3);
            repeat (count) text_q.push_back(8'($urandom_range(1, 255)));
         end
         if (mode < 25) begin
            pos = $urandom_range(0, text_q.size());
            text_q.insert(pos, corrupt_byte());
         end
      end
   endtask

   initial begin
      int random_start;
      int numeral_count;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_character = CHAR_END;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // Empty numerals, signs, suffix, points and stray bytes.
      send_string("");
      send_string("-");
      send_string(".");
      send_string("-1.5");
      send_string("f");
      text_q = '{CHAR_MINUS, CHAR_SUFFIX, 8'hFF};
      send_text();
      send_string("1-");
      send_string("..");
      text_q = '{8'hFF};
      send_text();
      drain_conversions();

      // Stall the result side for a long stretch while terminators pile up.
      holds_requested++;
      sender_calm = 1'b1;
      repeat (40) send_string("7");
      sender_calm = 1'b0;
      drain_conversions();

      random_start  = items_sent;
      numeral_count = 0;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         sender_calm   = (numeral_count % 100) >= 85;
         receiver_calm = sender_calm;
         make_numeral();
         send_text();
         numeral_count++;
         if (numeral_count % 120 == 0) drain_conversions();
      end
      sender_calm   = 1'b0;
      receiver_calm = 1'b0;

      drain_conversions();
      repeat (20) @(negedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
